@@ rtl/nnis_pkg.sv @@
// ----------------------------------------------------------------------------
// nnis_pkg
// Types and constants used by the nearest-neighbor scaler core.
// ----------------------------------------------------------------------------
package nnis_pkg;

  // field widths fixed by the item formats
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixelW  = 3 * ChanW;
  localparam int unsigned SrcDimW = 9;
  localparam int unsigned OutDimW = 12;
  localparam int unsigned ScaleW  = 24;
  localparam int unsigned FracW   = 16;
  localparam int unsigned ProdW   = ScaleW + OutDimW;
  localparam int unsigned IdxW    = ProdW - FracW;
  localparam int unsigned RowBaseW = 2 * SrcDimW;

  // apb register map
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_INV_SCALE  = 3'd4
  } cfg_reg_e;

  // action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ChanW-1:0]  in_blue;
    logic [ChanW-1:0]  in_green;
    logic [ChanW-1:0]  in_red;
  } in_t;

  typedef struct packed {
    logic [ChanW-1:0]  out_blue;
    logic [ChanW-1:0]  out_green;
    logic [ChanW-1:0]  out_red;
    logic [1:0]        row_padding;
    logic              row_end;
    logic              image_end;
  } out_t;

endpackage

@@ rtl/nnis_ram.sv @@
// ----------------------------------------------------------------------------
// nnis_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nnis_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one access per cycle, read data held while disabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/nearest_neighbor_image_scaler_core.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler_core
// Nearest-neighbor image resizer around a single-port frame store.
// ----------------------------------------------------------------------------
// an emit's pixel shows once it has passed stage 1, stage 2 and the output register
// throughput: one load or emit per cycle when not held; the single frame store port
//   takes the one read or write of each item in the third pipeline stage
// the whole pipeline holds while a result waits under stall
// reset clears counters and valids, presets config; data regs, frame store not cleared
module nearest_neighbor_image_scaler_core
  import nnis_pkg::*;
#(
  parameter int unsigned MAX_SRC_WIDTH  = 256,
  parameter int unsigned MAX_SRC_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // apb configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  localparam int unsigned Depth = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [SrcDimW-1:0] src_width_q, src_height_q;
  logic [OutDimW-1:0] out_width_q, out_height_q;
  logic [ScaleW-1:0]  inv_scale_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= SrcDimW'(256);
      src_height_q <= SrcDimW'(256);
      out_width_q  <= OutDimW'(256);
      out_height_q <= OutDimW'(256);
      inv_scale_q  <= ScaleW'(65536);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SRC_WIDTH:  src_width_q  <= pwdata[SrcDimW-1:0];
        REG_SRC_HEIGHT: src_height_q <= pwdata[SrcDimW-1:0];
        REG_OUT_WIDTH:  out_width_q  <= pwdata[OutDimW-1:0];
        REG_OUT_HEIGHT: out_height_q <= pwdata[OutDimW-1:0];
        REG_INV_SCALE:  inv_scale_q  <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_sel)
      REG_SRC_WIDTH:  prdata = CfgDataW'(src_width_q);
      REG_SRC_HEIGHT: prdata = CfgDataW'(src_height_q);
      REG_OUT_WIDTH:  prdata = CfgDataW'(out_width_q);
      REG_OUT_HEIGHT: prdata = CfgDataW'(out_height_q);
      REG_INV_SCALE:  prdata = CfgDataW'(inv_scale_q);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // effective sizes: zero acts as one, source clamps to the store limits
  // --------------------------------------------------------------------------
  logic [SrcDimW-1:0]  src_w, src_h;
  logic [OutDimW-1:0]  out_w, out_h;
  logic [RowBaseW-1:0] total;

  always_comb begin
    if (src_width_q == '0) begin
      src_w = SrcDimW'(1);
    end else if (32'(src_width_q) > 32'(MAX_SRC_WIDTH)) begin
      src_w = SrcDimW'(MAX_SRC_WIDTH);
    end else begin
      src_w = src_width_q;
    end
    if (src_height_q == '0) begin
      src_h = SrcDimW'(1);
    end else if (32'(src_height_q) > 32'(MAX_SRC_HEIGHT)) begin
      src_h = SrcDimW'(MAX_SRC_HEIGHT);
    end else begin
      src_h = src_height_q;
    end
    out_w = (out_width_q == '0)  ? OutDimW'(1) : out_width_q;
    out_h = (out_height_q == '0) ? OutDimW'(1) : out_height_q;
  end

  assign total = RowBaseW'(src_w) * RowBaseW'(src_h);

  // --------------------------------------------------------------------------
  // pipeline advance: everything holds while a result waits
  // --------------------------------------------------------------------------
  logic adv;
  logic in_accept;
  logic is_emit;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_emit    = (in_data_i.action == ACT_EMIT);

  // --------------------------------------------------------------------------
  // stage 0: load counter and emit position
  // --------------------------------------------------------------------------
  logic [AddrW-1:0]   load_q, load_d, load_cur;
  logic [AddrW:0]     load_inc;
  logic [OutDimW-1:0] row_q, row_d, col_q, col_d;
  logic               row_end, image_end;

  always_comb begin
    load_cur = (32'(load_q) >= 32'(total)) ? '0 : load_q;
    load_inc = (AddrW+1)'(load_cur) + (AddrW+1)'(1);
    load_d   = (32'(load_inc) >= 32'(total)) ? '0 : load_inc[AddrW-1:0];
  end

  assign row_end   = ((OutDimW+1)'(col_q) + (OutDimW+1)'(1)) >= (OutDimW+1)'(out_w);
  assign image_end = row_end &&
                     (((OutDimW+1)'(row_q) + (OutDimW+1)'(1)) >= (OutDimW+1)'(out_h));

  // next output position
  always_comb begin
    priority if (image_end) begin
      row_d = '0;
      col_d = '0;
    end else if (row_end) begin
      row_d = row_q + OutDimW'(1);
      col_d = '0;
    end else begin
      row_d = row_q;
      col_d = col_q + OutDimW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (in_accept) begin
      if (is_emit) begin
        row_q <= row_d;
        col_q <= col_d;
      end else begin
        load_q <= load_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: scaled positions
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic              emit;
    logic [PixelW-1:0] pixel;
    logic [AddrW-1:0]  load_addr;
    logic [1:0]        pad;
    logic              row_end;
    logic              image_end;
  } item_t;

  logic              s1_valid_q;
  item_t             s1_q;
  logic [ProdW-1:0]  s1_prod_r_q, s1_prod_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.emit      <= is_emit;
      s1_q.pixel     <= {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue};
      s1_q.load_addr <= load_cur;
      s1_q.pad       <= row_end ? out_w[1:0] : 2'd0;
      s1_q.row_end   <= row_end;
      s1_q.image_end <= image_end;
      s1_prod_r_q    <= ProdW'(inv_scale_q) * ProdW'(row_q);
      s1_prod_c_q    <= ProdW'(inv_scale_q) * ProdW'(col_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: saturate source indices, row base address
  // --------------------------------------------------------------------------
  logic [IdxW-1:0]     idx_r, idx_c;
  logic [SrcDimW-1:0]  src_r, src_c;
  logic                s2_valid_q;
  item_t               s2_q;
  logic [RowBaseW-1:0] s2_base_q;
  logic [SrcDimW-1:0]  s2_col_q;

  assign idx_r = s1_prod_r_q[ProdW-1:FracW];
  assign idx_c = s1_prod_c_q[ProdW-1:FracW];
  assign src_r = (idx_r >= IdxW'(src_h)) ? (src_h - SrcDimW'(1)) : idx_r[SrcDimW-1:0];
  assign src_c = (idx_c >= IdxW'(src_w)) ? (src_w - SrcDimW'(1)) : idx_c[SrcDimW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q      <= s1_q;
      s2_base_q <= RowBaseW'(src_r) * RowBaseW'(src_w);
      s2_col_q  <= src_c;
    end
  end

  // --------------------------------------------------------------------------
  // frame store access: loads write, emits read, in arrival order
  // --------------------------------------------------------------------------
  logic [AddrW-1:0]  ram_addr;
  logic [PixelW-1:0] ram_rdata;

  assign ram_addr = s2_q.emit
                  ? AddrW'((RowBaseW+1)'(s2_base_q) + (RowBaseW+1)'(s2_col_q))
                  : s2_q.load_addr;

  nnis_ram #(
    .WIDTH (PixelW),
    .DEPTH (Depth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .en_i    (adv && s2_valid_q),
    .we_i    (!s2_q.emit),
    .addr_i  (ram_addr),
    .wdata_i (s2_q.pixel),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // stage 3: output register, read data comes from the store
  // --------------------------------------------------------------------------
  logic       out_valid_q;
  logic [1:0] out_pad_q;
  logic       out_row_end_q, out_image_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q && s2_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pad_q       <= s2_q.pad;
      out_row_end_q   <= s2_q.row_end;
      out_image_end_q <= s2_q.image_end;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.out_blue    = ram_rdata[ChanW-1:0];
  assign out_data_o.out_green   = ram_rdata[2*ChanW-1:ChanW];
  assign out_data_o.out_red     = ram_rdata[3*ChanW-1:2*ChanW];
  assign out_data_o.row_padding = out_pad_q;
  assign out_data_o.row_end     = out_row_end_q;
  assign out_data_o.image_end   = out_image_end_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // last pixel of the image is always last of its row
  a_image_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.image_end || out_data_o.row_end))
    else $error("image end without row end");

  // padding appears only at a row end
  a_pad_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.row_end) |-> (out_data_o.row_padding == 2'd0))
    else $error("row padding inside a row");

  // load counter stays inside the loaded image
  a_load_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !is_emit && !cfg_wr) |=> (32'(load_q) < 32'(total)))
    else $error("load counter past pixel count");

endmodule
